### rtl/core/assert_macros.svh
// Assertion macros for the RTL files; the back end includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/core/gcr_pkg.sv
// Types, command codes and response byte helpers for the controller responder.
`default_nettype none
package gcr_pkg;

  localparam logic [7:0] CMD_IDENT  = 8'h00;
  localparam logic [7:0] CMD_POLL   = 8'h40;
  localparam logic [7:0] CMD_ORIGIN = 8'h41;

  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_ORIGIN = 2'd1;
  localparam logic [1:0] KIND_POLL   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [15:0] END_SYMBOL = 16'h0003;

  typedef struct packed {
    logic [7:0]  command_byte;
    logic [7:0]  rumble_byte;
    logic [63:0] report_data;
  } req_t;

  typedef struct packed {
    logic [31:0] line_word;
    logic        word_valid;
    logic        last;
    logic        receive_restart;
    logic        rumble_on;
  } rsp_t;

  // One classified command waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic        rumble_on;
    logic [63:0] report_data;
  } entry_t;

  // MSB first, data bit at even position, enable at odd position.
  function automatic logic [15:0] enc_byte(logic [7:0] b);
    logic [15:0] e;
    e = '0;
    for (int j = 0; j < 8; j++) begin
      e[2*j+1] = 1'b1;
      e[2*j]   = b[7-j];
    end
    return e;
  endfunction

  function automatic logic [3:0] byte_count(logic [1:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_IDENT:  n = 4'd3;
      KIND_ORIGIN: n = 4'd10;
      KIND_POLL:   n = 4'd8;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] byte_at(logic [1:0] kind, logic [63:0] report,
                                         logic [3:0] idx);
    logic [7:0] b;
    logic [2:0] sel;
    sel = 3'd7 - idx[2:0];
    case (kind)
      KIND_IDENT: begin
        case (idx)
          4'd0:    b = 8'h09;
          4'd2:    b = 8'h03;
          default: b = 8'h00;
        endcase
      end
      KIND_ORIGIN: b = (idx >= 4'd1 && idx <= 4'd5) ? 8'h80 : 8'h00;
      KIND_POLL:   b = report[{sel, 3'b000} +: 8];
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

  // One 16-bit half of a line word: a data byte, the end symbol or nothing.
  function automatic logic [15:0] half_word(logic [1:0] kind, logic [63:0] report,
                                            logic [3:0] idx);
    logic [3:0]  n;
    logic [15:0] h;
    n = byte_count(kind);
    if (idx < n) h = enc_byte(byte_at(kind, report, idx));
    else if (idx == n) h = END_SYMBOL;
    else h = 16'h0000;
    return h;
  endfunction

endpackage
`default_nettype wire

### rtl/core/gcr_front.sv
// Front end: classifies commands and tracks the held rumble level.
`default_nettype none
module gcr_front (
  input  logic            clk,
  input  logic            rst,
  input  gcr_pkg::req_t   req,
  input  logic            push,
  input  logic            q_full,
  output logic            q_wr,
  output gcr_pkg::entry_t q_data
);

  logic rumble_level;
  logic is_poll;

  assign is_poll = (req.command_byte == gcr_pkg::CMD_POLL);
  assign q_wr    = push && !q_full;

  always_comb begin
    q_data.report_data = req.report_data;
    q_data.rumble_on   = is_poll ? req.rumble_byte[0] : rumble_level;
    case (req.command_byte)
      gcr_pkg::CMD_IDENT:  q_data.kind = gcr_pkg::KIND_IDENT;
      gcr_pkg::CMD_ORIGIN: q_data.kind = gcr_pkg::KIND_ORIGIN;
      gcr_pkg::CMD_POLL:   q_data.kind = gcr_pkg::KIND_POLL;
      default:             q_data.kind = gcr_pkg::KIND_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rumble_level <= 1'b0;
    end else if (q_wr && is_poll) begin
      rumble_level <= req.rumble_byte[0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/gcr_fifo.sv
// Short command queue between front and back end.
`default_nettype none
module gcr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gcr_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd,
  output gcr_pkg::entry_t rd_data,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  gcr_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/gcr_back.sv
// Back end: turns the queue head into line words, one per cycle while each word is popped.
`default_nettype none
`include "assert_macros.svh"
module gcr_back (
  input  logic            clk,
  input  logic            rst,
  input  gcr_pkg::entry_t head,
  input  logic            head_valid,
  output logic            head_pop,
  output gcr_pkg::rsp_t   rsp,
  output logic            rsp_valid,
  input  logic            pop
);

  logic [2:0]    word_idx;
  logic [3:0]    n_bytes;
  logic          is_err;
  logic          last_w;
  logic          emit;
  gcr_pkg::rsp_t word;

  assign n_bytes  = gcr_pkg::byte_count(head.kind);
  assign is_err   = (head.kind == gcr_pkg::KIND_ERROR);
  assign last_w   = is_err || (word_idx == n_bytes[3:1]);
  assign emit     = head_valid && (!rsp_valid || pop);
  assign head_pop = emit && last_w;

  always_comb begin
    word.word_valid      = !is_err;
    word.last            = last_w;
    word.receive_restart = is_err;
    word.rumble_on       = head.rumble_on;
    if (is_err) begin
      word.line_word = 32'h0;
    end else begin
      word.line_word = {gcr_pkg::half_word(head.kind, head.report_data, {word_idx, 1'b1}),
                        gcr_pkg::half_word(head.kind, head.report_data, {word_idx, 1'b0})};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      word_idx  <= '0;
    end else begin
      if (emit) rsp_valid <= 1'b1;
      else if (pop) rsp_valid <= 1'b0;
      if (emit) word_idx <= last_w ? 3'd0 : word_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rsp <= word;
  end

  `ASSERT_IMPL(a_idx_range, clk, rst, 1'b1, word_idx <= 3'd5)
  `ASSERT_IMPL(a_err_single, clk, rst, head_valid && is_err, last_w && word_idx == 3'd0)
  `ASSERT_NEXT(a_emit_loads, clk, rst, emit, rsp_valid && rsp.last == $past(last_w))

endmodule
`default_nettype wire

### rtl/core/gc_controller_responder.sv
// Top level of the controller protocol responder: front end, queue, back end.
`default_nettype none
// Device side of a game-controller serial link. Each beat on the request side
// is one received command. Identify (0x00) answers with 2 line words, origin
// (0x41) with 6, poll (0x40) with 5, and any other command with a single beat
// that has receive_restart set and no data. A poll also latches bit 0 of
// rumble_byte as the held rumble level, which every result beat reports in
// rumble_on. Line words hold two response bytes, the first in bits 15:0, each
// bit sent MSB first as a 2-bit symbol (data at the even bit, enable at the
// odd bit), with a 0b11 end symbol in the slot after the last byte.
// Rate: the back end produces one result beat per cycle while pop keeps up, and
// a command has 1 to 6 result beats. The front end takes a new command every
// cycle while the queue of QUEUE_DEPTH commands has room, and the first result
// beat of a command that reaches an empty back end is written into the queue,
// then loaded into the result register, before it shows on the outputs.
module gc_controller_responder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  gcr_pkg::req_t req,
  input  logic          push,
  output logic          full,
  output gcr_pkg::rsp_t rsp,
  output logic          empty,
  input  logic          pop
);

  logic            q_wr;
  gcr_pkg::entry_t q_wr_data;
  logic            q_full;
  logic            q_rd;
  gcr_pkg::entry_t q_head;
  logic            q_empty;
  logic            rsp_valid;

  // Full follows the queue only; the front end never holds a command itself.
  assign full  = q_full;
  assign empty = !rsp_valid;

  // Classify the command and pick the rumble level its results carry.
  gcr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .push   (push),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wr_data)
  );

  // Decouples command intake from the multi-beat responses.
  gcr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Head entry stays in the queue until its last word is loaded.
  gcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_pop   (q_rd),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid),
    .pop        (pop)
  );

endmodule
`default_nettype wire

### verif/gcr_reply_checker.sv
// Reply checker for the controller responder: predicts line-word beats and compares them.
module gcr_reply_checker (
  input  logic          clk,
  input  logic          rst,
  input  gcr_pkg::req_t req,
  input  logic          push,
  input  logic          full,
  input  gcr_pkg::rsp_t rsp,
  input  logic          empty,
  input  logic          pop,
  output int            mismatches,
  output int            replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          REPORT_LIMIT = 10;
  localparam logic [15:0] STOP_SYMBOL  = 16'h0003;

  gcr_pkg::rsp_t expected_replies[$];
  logic          held_rumble;

  initial begin
    mismatches  = 0;
    replies_due = 0;
    held_rumble = 1'b0;
  end

  // One byte as eight 2-bit symbols, MSB in the lowest slot.
  function automatic logic [15:0] byte_symbols(input logic [7:0] b);
    logic [15:0] s;
    s = '0;
    for (int k = 0; k < 8; k++) s[2*k +: 2] = {1'b1, b[7-k]};
    return s;
  endfunction

  // Queue the reply beats one command should produce.
  task automatic predict_reply(input gcr_pkg::req_t r);
    logic [7:0]    bytes[10];
    logic [31:0]   words[6];
    int            n;
    int            nw;
    gcr_pkg::rsp_t beat;
    foreach (bytes[i]) bytes[i] = 8'h00;
    foreach (words[i]) words[i] = 32'h0;
    n = 0;
    if (r.command_byte == gcr_pkg::CMD_IDENT) begin
      bytes[0] = 8'h09;
      bytes[2] = 8'h03;
      n = 3;
    end else if (r.command_byte == gcr_pkg::CMD_ORIGIN) begin
      for (int i = 1; i <= 5; i++) bytes[i] = 8'h80;
      n = 10;
    end else if (r.command_byte == gcr_pkg::CMD_POLL) begin
      held_rumble = r.rumble_byte[0];
      for (int i = 0; i < 8; i++) bytes[i] = r.report_data[63-8*i -: 8];
      n = 8;
    end
    if (n == 0) begin
      // unknown command: single restart beat, no data
      beat.line_word       = 32'h0;
      beat.word_valid      = 1'b0;
      beat.last            = 1'b1;
      beat.receive_restart = 1'b1;
      beat.rumble_on       = held_rumble;
      expected_replies.push_back(beat);
    end else begin
      nw = n / 2 + 1;
      for (int i = 0; i < n; i++) words[i/2][16*(i%2) +: 16] = byte_symbols(bytes[i]);
      words[n/2][16*(n%2) +: 16] = STOP_SYMBOL;
      for (int w = 0; w < nw; w++) begin
        beat.line_word       = words[w];
        beat.word_valid      = 1'b1;
        beat.last            = (w == nw - 1);
        beat.receive_restart = 1'b0;
        beat.rumble_on       = held_rumble;
        expected_replies.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    gcr_pkg::rsp_t want;
    if (rst) begin
      held_rumble = 1'b0;
      expected_replies.delete();
    end else begin
      if (push && !full) predict_reply(req);
      if (pop && !empty) begin
        if (expected_replies.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t unexpected beat: word=%h valid=%b last=%b restart=%b rumble=%b",
                     $realtime, rsp.line_word, rsp.word_valid, rsp.last,
                     rsp.receive_restart, rsp.rumble_on);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display({"%0t beat mismatch: exp word=%h valid=%b last=%b restart=%b ",
                        "rumble=%b / got word=%h valid=%b last=%b restart=%b rumble=%b"},
                       $realtime, want.line_word, want.word_valid, want.last,
                       want.receive_restart, want.rumble_on, rsp.line_word,
                       rsp.word_valid, rsp.last, rsp.receive_restart, rsp.rumble_on);
            mismatches++;
          end
        end
      end
    end
    replies_due = expected_replies.size();
  end

endmodule

### verif/tb_gc_controller_responder.sv
// Testbench top for the controller responder: stimulus, result drain, watchdog and verdict.
module tb_gc_controller_responder;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest honest quiet stretch is a send gap plus a pop stall and the path
  // through the queue and the result register; this is many times that.
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int DRAIN_CYCLES  = 20;

  logic          clk = 1'b0;
  logic          rst;
  gcr_pkg::req_t req;
  logic          push;
  logic          full;
  gcr_pkg::rsp_t rsp;
  logic          empty;
  logic          pop;

  int            mismatches;
  int            replies_due;
  int            quiet_cycles;
  logic          no_idle;   // set for a stretch with no gaps on either side

  gc_controller_responder dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .push  (push),
    .full  (full),
    .rsp   (rsp),
    .empty (empty),
    .pop   (pop)
  );

  gcr_reply_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .push        (push),
    .full        (full),
    .rsp         (rsp),
    .empty       (empty),
    .pop         (pop),
    .mismatches  (mismatches),
    .replies_due (replies_due)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: any accepted beat on either side resets the quiet count.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic gcr_pkg::req_t make_cmd(input logic [7:0] cmd, input logic [7:0] rum,
                                             input logic [63:0] rep);
    gcr_pkg::req_t r;
    r.command_byte = cmd;
    r.rumble_byte  = rum;
    r.report_data  = rep;
    return r;
  endfunction

  // Mostly well-formed commands with random payload; a fifth are arbitrary
  // command bytes, which land on the restart path nearly always.
  function automatic gcr_pkg::req_t random_cmd();
    int          pick;
    logic [7:0]  cmd;
    pick = $urandom_range(0, 9);
    if (pick < 2) cmd = gcr_pkg::CMD_IDENT;
    else if (pick < 4) cmd = gcr_pkg::CMD_ORIGIN;
    else if (pick < 8) cmd = gcr_pkg::CMD_POLL;
    else cmd = 8'($urandom_range(0, 255));
    return make_cmd(cmd, 8'($urandom_range(0, 255)), {$urandom, $urandom});
  endfunction

  // Drive one request beat. Called at a falling edge, returns at the falling
  // edge after the beat was taken, so push is never lowered and raised in
  // one step: a zero gap just keeps push high with the new payload.
  task automatic send_cmd(input gcr_pkg::req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      req  <= make_cmd(8'($urandom), 8'($urandom), {$urandom, $urandom}); // idle noise
      repeat (gap) @(negedge clk);
    end
    req  <= r;
    push <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted beat has been drained.
  task automatic drain_replies();
    push <= 1'b0;
    @(negedge clk);
    while (replies_due != 0) @(negedge clk);
  endtask

  // Result side: random stall before each beat.
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin
    rst     = 1'b1;
    push    = 1'b0;
    req     = '0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: first identify checks the reset rumble level.
    send_cmd(make_cmd(gcr_pkg::CMD_IDENT,  8'h00, 64'h0));
    send_cmd(make_cmd(gcr_pkg::CMD_ORIGIN, 8'h00, 64'h0));
    // poll turns rumble on, all-ones report
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'h01, 64'hFFFF_FFFF_FFFF_FFFF));
    // non-poll commands ignore payload, rumble stays held
    send_cmd(make_cmd(gcr_pkg::CMD_IDENT,  8'hFE, 64'hFFFF_FFFF_FFFF_FFFF));
    send_cmd(make_cmd(8'hFF,               8'h00, 64'h0));
    send_cmd(make_cmd(gcr_pkg::CMD_ORIGIN, 8'hFF, 64'h1234_5678_9ABC_DEF0));
    // only bit 0 of the rumble byte counts
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'hFE, 64'h0));
    send_cmd(make_cmd(8'h01,               8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'hFF, 64'h0123_4567_89AB_CDEF));
    // unknown commands right next to the real codes
    send_cmd(make_cmd(8'h3F,               8'h01, 64'h0));
    send_cmd(make_cmd(8'h42,               8'h01, 64'h0));
    send_cmd(make_cmd(8'h80,               8'h00, 64'h0));
    send_cmd(make_cmd(8'hC0,               8'h00, 64'h0));
    send_cmd(make_cmd(8'h7F,               8'h00, 64'h0));
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'h00, 64'h8000_0000_0000_0001));
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'h01, 64'hAAAA_AAAA_AAAA_AAAA));
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'h80, 64'h5555_5555_5555_5555));
    send_cmd(make_cmd(8'hFF,               8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_cmd(make_cmd(gcr_pkg::CMD_IDENT,  8'h00, 64'h0));
    // back-to-back polls flipping rumble
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'h01, 64'h00FF_00FF_00FF_00FF));
    send_cmd(make_cmd(gcr_pkg::CMD_POLL,   8'h00, 64'hFF00_FF00_FF00_FF00));
    send_cmd(make_cmd(gcr_pkg::CMD_ORIGIN, 8'h01, 64'h0));

    // Sender pauses here until the block has gone fully idle.
    drain_replies();

    // Random part, with a gap-free stretch in the middle to fill the queue.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 30 && n < 60);
      if (n == 80) drain_replies();
      send_cmd(random_cmd());
    end
    no_idle = 1'b0;
    push <= 1'b0;

    // Wait for the remaining beats, then a short tail for anything stray.
    @(negedge clk);
    while (replies_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && replies_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
